>>> src/cam_pkg.sv
// ----------------------------------------------------------------------------
// Cartridge address mapper package
// Shared item types, configuration codes and the bank slot helper.
// ----------------------------------------------------------------------------
package cam_pkg;

    localparam int unsigned ADDR_W     = 24;
    localparam int unsigned HDR_W      = 15;
    localparam int unsigned BANK_W     = 3;
    localparam int unsigned NUM_SLOTS  = 8;
    localparam int unsigned SLOTS_W    = BANK_W * NUM_SLOTS;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 24;

    localparam logic [SLOTS_W-1:0] BANK_SLOTS_RESET = 24'hFAC688;

    localparam logic [CFG_IDX_W-1:0] REG_MAP_MODE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BANK_SLOTS   = 2'd2;

    localparam logic OP_FILE_TO_BUS = 1'b0;
    localparam logic OP_BUS_TO_FILE = 1'b1;

    typedef enum logic [1:0] {
        MODE_LOROM       = 2'd0,
        MODE_SA1_BANKED  = 2'd1,
        MODE_SA1_FULL    = 2'd2,
        MODE_UNSUPPORTED = 2'd3
    } map_mode_t;

    typedef struct packed {
        logic              operation;
        logic [ADDR_W-1:0] address;
    } cam_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] mapped_address;
        logic              valid_res;
    } cam_out_t;

    typedef struct packed {
        map_mode_t          map_mode;
        logic [HDR_W-1:0]   header_bytes;
        logic [SLOTS_W-1:0] bank_slots;
    } cam_cfg_t;

    function automatic logic [BANK_W-1:0] slot_bank(
        input logic [SLOTS_W-1:0] slots,
        input logic [BANK_W-1:0]  idx
    );
        int unsigned base;
        base = int'(idx) * BANK_W;
        return slots[base +: BANK_W];
    endfunction

endpackage

>>> src/cam_translate.sv
// ----------------------------------------------------------------------------
// Cartridge address mapper translation
// File offset to bus address and bus address to file offset, one item.
// ----------------------------------------------------------------------------
module cam_translate (
    input  cam_pkg::cam_cfg_t cfg,
    input  cam_pkg::cam_in_t  item_in,
    output cam_pkg::cam_out_t item_out
);

    logic [cam_pkg::ADDR_W-1:0] addr;
    logic [cam_pkg::ADDR_W-1:0] hdr;
    logic [cam_pkg::ADDR_W-1:0] fwd_base;
    logic                       in_header;
    logic                       slot_hit;
    logic [cam_pkg::BANK_W-1:0] slot_idx;
    logic [cam_pkg::ADDR_W-1:0] fwd_res;
    logic                       fwd_ok;
    logic [cam_pkg::ADDR_W-1:0] rev_off;
    logic                       rev_ok;
    logic [cam_pkg::BANK_W-1:0] lo_bank;
    logic [cam_pkg::BANK_W-1:0] hi_bank;

    assign addr      = item_in.address;
    assign hdr       = {{(cam_pkg::ADDR_W - cam_pkg::HDR_W){1'b0}}, cfg.header_bytes};
    assign in_header = addr < hdr;
    assign fwd_base  = addr - hdr;

    // first slot holding the offset's megabyte
    always_comb begin
        slot_hit = 1'b0;
        slot_idx = '0;
        for (int i = cam_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
            if (cam_pkg::slot_bank(cfg.bank_slots, cam_pkg::BANK_W'(i)) == fwd_base[22:20]) begin
                slot_hit = 1'b1;
                slot_idx = cam_pkg::BANK_W'(i);
            end
        end
    end

    always_comb begin
        fwd_res = '0;
        fwd_ok  = 1'b0;
        case (cfg.map_mode)
            cam_pkg::MODE_LOROM: begin
                fwd_res = {1'b0, fwd_base[21:15], 1'b1, fwd_base[14:0]};
                fwd_ok  = 1'b1;
            end
            cam_pkg::MODE_SA1_BANKED: begin
                fwd_res = {slot_idx, fwd_base[19:15], 1'b1, fwd_base[14:0]};
                fwd_ok  = slot_hit;
            end
            cam_pkg::MODE_SA1_FULL: begin
                if (fwd_base[22]) begin
                    fwd_res = {2'b11, fwd_base[21:0]};
                end else begin
                    fwd_res = {fwd_base[21], 1'b0, fwd_base[20:15], 1'b1, fwd_base[14:0]};
                end
                fwd_ok = 1'b1;
            end
            default: begin
                fwd_res = '0;
                fwd_ok  = 1'b0;
            end
        endcase
        if (in_header) begin
            fwd_ok = 1'b0;
        end
    end

    assign lo_bank = cam_pkg::slot_bank(cfg.bank_slots, addr[23:21]);
    assign hi_bank = cam_pkg::slot_bank(cfg.bank_slots, {addr[21], 1'b0, addr[20]});

    always_comb begin
        rev_off = '0;
        rev_ok  = 1'b0;
        case (cfg.map_mode)
            cam_pkg::MODE_LOROM: begin
                rev_off = {2'b00, addr[22:16], addr[14:0]};
                rev_ok  = !((addr[23:17] == 7'h3F) ||
                            (!addr[22] && !addr[15]) ||
                            (addr[22:20] == 3'b111 && !addr[15]));
            end
            cam_pkg::MODE_SA1_BANKED: begin
                if (!addr[22] && addr[15]) begin
                    rev_off = {1'b0, lo_bank, addr[20:16], addr[14:0]};
                    rev_ok  = 1'b1;
                end else if (addr[23:22] == 2'b11) begin
                    rev_off = {1'b0, hi_bank, addr[19:0]};
                    rev_ok  = 1'b1;
                end
            end
            cam_pkg::MODE_SA1_FULL: begin
                if (addr[23:22] == 2'b11) begin
                    rev_off = {2'b01, addr[21:0]};
                    rev_ok  = 1'b1;
                end else if (!addr[22] && addr[15]) begin
                    rev_off = {2'b00, addr[23], addr[21:16], addr[14:0]};
                    rev_ok  = 1'b1;
                end
            end
            default: begin
                rev_off = '0;
                rev_ok  = 1'b0;
            end
        endcase
    end

    always_comb begin
        item_out = '0;
        if (item_in.operation == cam_pkg::OP_FILE_TO_BUS) begin
            if (fwd_ok) begin
                item_out.mapped_address = fwd_res;
                item_out.valid_res      = 1'b1;
            end
        end else begin
            if (rev_ok) begin
                item_out.mapped_address = rev_off + hdr;
                item_out.valid_res      = 1'b1;
            end
        end
    end

endmodule

>>> src/cartridge_address_mapper_top.sv
// ----------------------------------------------------------------------------
// Cartridge address mapper
// Translates between cartridge image offsets and 24-bit console bus addresses.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per translation (operation, address), valid/ready.
//   m_ channel: one result item per input item (mapped_address, valid_res),
//   valid/ready, in input order. valid_res low means unmapped or an
//   unsupported mode; mapped_address is then zero.
//   Configuration: cfg_write with cfg_index selects map mode, header size or
//   the bank slot word; write only while no item is in flight.
// Timing:
//   The input register loads on the input accept edge and the result register
//   takes the translated item from it when the result is free or leaving.
//   One item per cycle sustained while m_ready is high: the translation is a
//   single pass of masking, one subtract or add and an eight-way slot compare.
// Reset:
//   aresetn low empties both stages and restores LoROM, no header and slot i
//   holding bank i.
// Stall:
//   While m_ready is low the result holds; one further item is taken into
//   the input register, after which s_ready drops until the result leaves.
// ----------------------------------------------------------------------------
module cartridge_address_mapper_top (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  cam_pkg::cam_in_t               s_item,
    output logic                           m_valid,
    input  logic                           m_ready,
    output cam_pkg::cam_out_t              m_item,
    input  logic                           cfg_write,
    input  logic [cam_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cam_pkg::CFG_DATA_W-1:0] cfg_data
);

    cam_pkg::cam_cfg_t  cfg_reg,      cfg_next;
    logic               in_vld_reg,   in_vld_next;
    cam_pkg::cam_in_t   in_item_reg,  in_item_next;
    logic               out_vld_reg,  out_vld_next;
    cam_pkg::cam_out_t  out_item_reg, out_item_next;
    cam_pkg::cam_out_t  xlat_item;
    logic               out_take;

    cam_translate u_translate (
        .cfg      (cfg_reg),
        .item_in  (in_item_reg),
        .item_out (xlat_item)
    );

    assign out_take = !out_vld_reg || m_ready;
    assign s_ready  = !in_vld_reg || out_take;
    assign m_valid  = out_vld_reg;
    assign m_item   = out_item_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_write) begin
            unique case (cfg_index)
                cam_pkg::REG_MAP_MODE:
                    cfg_next.map_mode = cam_pkg::map_mode_t'(cfg_data[1:0]);
                cam_pkg::REG_HEADER_BYTES:
                    cfg_next.header_bytes = cfg_data[cam_pkg::HDR_W-1:0];
                cam_pkg::REG_BANK_SLOTS:
                    cfg_next.bank_slots = cfg_data[cam_pkg::SLOTS_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        in_vld_next   = in_vld_reg;
        in_item_next  = in_item_reg;
        out_vld_next  = out_vld_reg;
        out_item_next = out_item_reg;
        if (s_ready) begin
            in_vld_next  = s_valid;
            in_item_next = s_item;
        end
        if (out_take) begin
            out_vld_next  = in_vld_reg;
            out_item_next = xlat_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.map_mode     <= cam_pkg::MODE_LOROM;
            cfg_reg.header_bytes <= '0;
            cfg_reg.bank_slots   <= cam_pkg::BANK_SLOTS_RESET;
            in_vld_reg           <= 1'b0;
            out_vld_reg          <= 1'b0;
        end else begin
            cfg_reg     <= cfg_next;
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_item_reg  <= in_item_next;
        out_item_reg <= out_item_next;
    end

`ifndef SYNTHESIS
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.valid_res |-> m_item.mapped_address == '0)
        else $error("invalid result carries a non-zero address");

    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && !out_take |=> in_vld_reg && $stable(in_item_reg))
        else $error("stalled input item lost or changed");

    a_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && out_take |=> m_valid)
        else $error("item did not reach the result register");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        in_vld_reg && out_vld_reg && !m_ready |-> !s_ready)
        else $error("input accepted with both stages full");
`endif

endmodule

>>> test/cam_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cartridge address mapper checker
// Tracks the configuration writes, predicts the translation of each accepted
// item and compares every result item, field by field, in order.
// ----------------------------------------------------------------------------
module cam_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  cam_pkg::cam_in_t               s_item,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  cam_pkg::cam_out_t              m_item,
    input  logic                           cfg_write,
    input  logic [cam_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cam_pkg::CFG_DATA_W-1:0] cfg_data,
    output int unsigned                    fail_count,
    output int unsigned                    in_flight
);
    import cam_pkg::*;

    cam_cfg_t cfg_q = '{MODE_LOROM, '0, BANK_SLOTS_RESET};
    cam_out_t pending_maps[$];

    initial begin
        fail_count = 0;
        in_flight  = 0;
    end

    function automatic logic [BANK_W-1:0] bank_of(input int unsigned slot);
        return cfg_q.bank_slots[BANK_W*slot +: BANK_W];
    endfunction

    function automatic cam_out_t map_address(input cam_in_t it);
        logic [ADDR_W-1:0] a;
        logic [ADDR_W-1:0] off;
        logic [ADDR_W-1:0] hdr;
        logic              hit;
        int                i;
        cam_out_t          r;
        r   = '0;
        hit = 1'b0;
        off = '0;
        a   = it.address;
        hdr = {9'd0, cfg_q.header_bytes};
        if (it.operation == OP_FILE_TO_BUS) begin
            if (a >= hdr) begin
                a = a - hdr;
                case (cfg_q.map_mode)
                    MODE_LOROM: begin
                        off = {1'b0, a[21:15], 1'b1, a[14:0]};
                        hit = 1'b1;
                    end
                    MODE_SA1_BANKED: begin
                        // lowest matching slot wins; offset bit 23 plays no part
                        for (i = 7; i >= 0; i--) begin
                            if (bank_of(i) == a[22:20]) begin
                                off = {i[2:0], a[19:15], 1'b1, a[14:0]};
                                hit = 1'b1;
                            end
                        end
                    end
                    MODE_SA1_FULL: begin
                        hit = 1'b1;
                        if (a[22])
                            off = {2'b11, a[21:0]};
                        else if (!a[21])
                            off = {2'b00, a[20:15], 1'b1, a[14:0]};
                        else
                            off = {2'b10, a[20:15], 1'b1, a[14:0]};
                    end
                    default: ;
                endcase
            end
        end else begin
            case (cfg_q.map_mode)
                MODE_LOROM: begin
                    if (!(a[23:17] == 7'h3F || (!a[22] && !a[15]) ||
                          (a[22:20] == 3'b111 && !a[15]))) begin
                        off = {1'b0, a[22:16], a[14:0]};
                        hit = 1'b1;
                    end
                end
                MODE_SA1_BANKED: begin
                    if (!a[22] && a[15]) begin
                        off = {1'b0, bank_of(a[23:21]), a[20:16], a[14:0]};
                        hit = 1'b1;
                    end else if (a[23:22] == 2'b11) begin
                        off = {1'b0, bank_of({a[21], 1'b0, a[20]}), a[19:0]};
                        hit = 1'b1;
                    end
                end
                MODE_SA1_FULL: begin
                    if (a[23:22] == 2'b11) begin
                        off = {2'b01, a[21:0]};
                        hit = 1'b1;
                    end else if (!a[22] && a[15]) begin
                        off = {2'b00, a[23], a[21:16], a[14:0]};
                        hit = 1'b1;
                    end
                end
                default: ;
            endcase
            off = off + hdr;
        end
        if (hit) begin
            r.mapped_address = off;
            r.valid_res      = 1'b1;
        end
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        cam_out_t want;
        if (!aresetn) begin
            cfg_q <= '{MODE_LOROM, '0, BANK_SLOTS_RESET};
            pending_maps.delete();
        end else begin
            if (cfg_write) begin
                case (cfg_index)
                    REG_MAP_MODE:     cfg_q.map_mode     <= map_mode_t'(cfg_data[1:0]);
                    REG_HEADER_BYTES: cfg_q.header_bytes <= cfg_data[HDR_W-1:0];
                    REG_BANK_SLOTS:   cfg_q.bank_slots   <= cfg_data[SLOTS_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                pending_maps.push_back(map_address(s_item));
            if (m_valid && m_ready) begin
                if (pending_maps.size() == 0) begin
                    $display("%0t: unexpected item, address %06h valid %0b",
                             $time, m_item.mapped_address, m_item.valid_res);
                    fail_count++;
                end else begin
                    want = pending_maps.pop_front();
                    if (m_item.mapped_address !== want.mapped_address) begin
                        $display("%0t: mapped_address expected %06h actual %06h",
                                 $time, want.mapped_address, m_item.mapped_address);
                        fail_count++;
                    end
                    if (m_item.valid_res !== want.valid_res) begin
                        $display("%0t: valid_res expected %0b actual %0b",
                                 $time, want.valid_res, m_item.valid_res);
                        fail_count++;
                    end
                end
            end
        end
        in_flight <= pending_maps.size();
    end

endmodule

>>> test/tb_cartridge_address_mapper_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cartridge address mapper testbench
// Directed corner items in every map mode, then random items over several
// configurations and idle patterns; the checker reports every mismatch.
// ----------------------------------------------------------------------------
module tb_cartridge_address_mapper_top;
    import cam_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int          SEG_ITEMS   = 106;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    cam_in_t               s_item    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    cam_out_t              m_item;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int unsigned           fail_count;
    int unsigned           in_flight;
    int unsigned           cycle_count = 0;
    int unsigned           src_idle    = 0;
    int unsigned           snk_stall   = 0;
    logic [HDR_W-1:0]      cur_hdr     = '0;

    cartridge_address_mapper_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cam_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .in_flight  (in_flight)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= snk_stall);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic cam_in_t mk(input logic op, input logic [ADDR_W-1:0] addr);
        cam_in_t it;
        it.operation = op;
        it.address   = addr;
        return it;
    endfunction

    function automatic cam_in_t random_item(input logic [HDR_W-1:0] hdr);
        cam_in_t           it;
        logic [ADDR_W-1:0] a;
        it.operation = 1'($urandom_range(1));
        a = ADDR_W'($urandom);
        case ($urandom_range(7))
            0: a[23:16] = 8'h7E + 8'($urandom_range(1));
            1: a[23:16] = 8'h70 + 8'($urandom_range(13));
            2: a = {9'd0, hdr} + ADDR_W'($urandom_range(7)) - 24'd4;
            3: a[15] = 1'b1;
            default: ;
        endcase
        it.address = a;
        return it;
    endfunction

    task automatic send_item(input cam_in_t it);
        while ($urandom_range(99) < src_idle) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    // hold the sender off until every result is back
    task automatic drain();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (in_flight != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic configure(input map_mode_t mode, input logic [HDR_W-1:0] hdr,
                             input logic [SLOTS_W-1:0] slots);
        cfg_write <= 1'b1;
        cfg_index <= REG_MAP_MODE;
        cfg_data  <= {22'd0, mode};
        @(posedge aclk);
        cfg_index <= REG_HEADER_BYTES;
        cfg_data  <= {9'd0, hdr};
        @(posedge aclk);
        cfg_index <= REG_BANK_SLOTS;
        cfg_data  <= slots;
        @(posedge aclk);
        cfg_write <= 1'b0;
        cur_hdr = hdr;
    endtask

    initial begin : stimulus
        logic [HDR_W-1:0]   hdr;
        logic [SLOTS_W-1:0] slots;
        int                 seg;
        int                 k;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset configuration: LoROM, no header
        send_item(mk(OP_FILE_TO_BUS, 24'h000000));
        send_item(mk(OP_FILE_TO_BUS, 24'hFFFFFF));
        send_item(mk(OP_BUS_TO_FILE, 24'h7E8000));
        send_item(mk(OP_BUS_TO_FILE, 24'h001234));
        send_item(mk(OP_BUS_TO_FILE, 24'h700000));
        send_item(mk(OP_BUS_TO_FILE, 24'hFFFFFF));

        drain();
        configure(MODE_SA1_BANKED, 15'h0200, 24'h053977);
        send_item(mk(OP_FILE_TO_BUS, 24'h0001FF));
        send_item(mk(OP_FILE_TO_BUS, 24'h000200));
        send_item(mk(OP_FILE_TO_BUS, 24'hFFFFFF));
        send_item(mk(OP_BUS_TO_FILE, 24'h008000));
        send_item(mk(OP_BUS_TO_FILE, 24'hC00000));
        send_item(mk(OP_BUS_TO_FILE, 24'h400000));
        send_item(mk(OP_BUS_TO_FILE, 24'hFFFFFF));

        // every slot on bank 0: no match elsewhere, offset bit 23 ignored
        drain();
        configure(MODE_SA1_BANKED, 15'h0000, 24'h000000);
        send_item(mk(OP_FILE_TO_BUS, 24'h300000));
        send_item(mk(OP_FILE_TO_BUS, 24'h800000));

        drain();
        configure(MODE_SA1_FULL, 15'h7FFF, 24'hFFFFFF);
        send_item(mk(OP_FILE_TO_BUS, 24'h007FFE));
        send_item(mk(OP_FILE_TO_BUS, 24'h007FFF));
        send_item(mk(OP_FILE_TO_BUS, 24'h407FFF));
        send_item(mk(OP_FILE_TO_BUS, 24'h207FFF));
        send_item(mk(OP_BUS_TO_FILE, 24'hC00000));
        send_item(mk(OP_BUS_TO_FILE, 24'h408000));
        send_item(mk(OP_BUS_TO_FILE, 24'h800000));
        send_item(mk(OP_BUS_TO_FILE, 24'h808000));
        send_item(mk(OP_BUS_TO_FILE, 24'hFFFFFF));

        drain();
        configure(MODE_UNSUPPORTED, 15'h0000, BANK_SLOTS_RESET);
        send_item(mk(OP_FILE_TO_BUS, 24'h000000));
        send_item(mk(OP_BUS_TO_FILE, 24'h808000));

        for (seg = 0; seg < 8; seg++) begin
            drain();
            case (seg % 4)
                0: begin src_idle = 0;  snk_stall = 0;  end
                1: begin src_idle = 83; snk_stall = 0;  end
                2: begin src_idle = 0;  snk_stall = 83; end
                default: begin src_idle = 13; snk_stall = 13; end
            endcase
            case ($urandom_range(3))
                0: hdr = '0;
                1: hdr = 15'h7FFF;
                default: hdr = HDR_W'($urandom);
            endcase
            case ($urandom_range(3))
                0: slots = BANK_SLOTS_RESET;
                1: slots = SLOTS_W'($urandom);
                2: slots = {NUM_SLOTS{3'($urandom_range(7))}};
                default: slots = 24'hFFFFFF;
            endcase
            configure(map_mode_t'((seg + seg / 4) % 4), hdr, slots);
            for (k = 0; k < SEG_ITEMS; k++) begin
                if (k == SEG_ITEMS / 2)
                    drain();
                send_item(random_item(cur_hdr));
            end
        end

        drain();
        repeat (6) @(posedge aclk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> files.f
src/cam_pkg.sv
src/cam_translate.sv
src/cartridge_address_mapper_top.sv
test/cam_checker.sv
test/tb_cartridge_address_mapper_top.sv
